FILE: design/kfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe resampler package
// Shared widths, register indexes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package kfr_pkg;

   localparam int MAX_GAP    = 64;
   localparam int FRAME_RATE = 30;

   localparam int TIME_W    = 24;
   localparam int TIME_FRAC = 16;
   localparam int RAW_W     = 16;
   localparam int SCALE_W   = 24;
   localparam int POS_W     = 40;
   localparam int FRAME_W   = 13;
   localparam int FRAME_MAX = 2 ** FRAME_W - 1;
   localparam int AXES      = 3;

   localparam int RATE_W = $clog2(FRAME_RATE + 1);
   localparam int PROD_W = TIME_W + RATE_W;
   localparam int DIFF_W = POS_W + 1;
   localparam int GAP_W  = $clog2(MAX_GAP + 1);

   localparam int DIV_STEPS = DIFF_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SCALE_W;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1 << 20);

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Z = CSR_IDX_W'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DECIDE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FILL,
      ST_KEY_OUT
   } kfr_state_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic decide;
      logic div_start;
      logic fill_init;
      logic emit_fill;
      logic emit_key;
      logic skip_key;
   } kfr_cmd_type;

   typedef struct packed {
      logic emit_needed;
      logic fill_needed;
      logic div_done;
      logic fill_last;
      logic slot_free;
   } kfr_status_type;

endpackage

FILE: design/kfr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe request channel
// Carries one translation key per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kfr_req_if;
   import kfr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [TIME_W-1:0]       key_time;
   logic signed [RAW_W-1:0] raw_x;
   logic signed [RAW_W-1:0] raw_y;
   logic signed [RAW_W-1:0] raw_z;
   logic                    track_start;

   modport source (
      output valid, key_time, raw_x, raw_y, raw_z, track_start,
      input  ready
   );

   modport sink (
      input  valid, key_time, raw_x, raw_y, raw_z, track_start,
      output ready
   );

endinterface

FILE: design/kfr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position response channel
// Carries one resampled position per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kfr_rsp_if;
   import kfr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic                    is_fill;
   logic                    gap_overflow;
   logic                    last_of_run;

   modport source (
      output valid, pos_x, pos_y, pos_z, is_fill, gap_overflow, last_of_run,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, pos_z, is_fill, gap_overflow, last_of_run,
      output ready
   );

endinterface

FILE: design/kfr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap divider
// Restoring divider, one quotient bit per cycle, for a position difference
// magnitude over a small frame gap.
// ----------------------------------------------------------------------------
module kfr_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kfr_pkg::DIFF_W-1:0]    dividend,
   input  logic [kfr_pkg::GAP_W-1:0]     divisor,
   output logic [kfr_pkg::DIFF_W-1:0]    quotient,
   output logic [kfr_pkg::GAP_W-1:0]     remainder,
   output logic                          done
);
   import kfr_pkg::*;

   logic [DIFF_W-1:0]    work_ff, work_in;
   logic [GAP_W-1:0]     rem_ff, rem_in;
   logic [GAP_W-1:0]     div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [GAP_W:0]       trial;
   logic [GAP_W:0]       trial_sub;
   logic                 fits;

   assign trial     = {rem_ff, work_ff[DIFF_W-1]};
   assign fits      = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         work_in = {work_ff[DIFF_W-2:0], fits};
         rem_in  = fits ? trial_sub[GAP_W-1:0] : trial[GAP_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient  = work_ff;
   assign remainder = rem_ff;
   assign done      = (cnt_ff == '0);

endmodule

FILE: design/kfr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe resampler datapath
// Scale registers, key scaling and frame conversion, previous-key state,
// per-axis gap dividers with running fill accumulators, and the response
// output register.
// ----------------------------------------------------------------------------
module kfr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  kfr_pkg::kfr_cmd_type              cmd,
   output kfr_pkg::kfr_status_type           status,
   input  logic [kfr_pkg::TIME_W-1:0]        req_key_time,
   input  logic signed [kfr_pkg::RAW_W-1:0]  req_raw_x,
   input  logic signed [kfr_pkg::RAW_W-1:0]  req_raw_y,
   input  logic signed [kfr_pkg::RAW_W-1:0]  req_raw_z,
   input  logic                              req_track_start,
   input  logic                              csr_wr_en,
   input  logic [kfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kfr_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic signed [kfr_pkg::POS_W-1:0]  rsp_pos_x,
   output logic signed [kfr_pkg::POS_W-1:0]  rsp_pos_y,
   output logic signed [kfr_pkg::POS_W-1:0]  rsp_pos_z,
   output logic                              rsp_is_fill,
   output logic                              rsp_gap_overflow,
   output logic                              rsp_last_of_run
);
   import kfr_pkg::*;

   // Configuration.
   logic [SCALE_W-1:0] scale_ff [AXES];
   logic [SCALE_W-1:0] scale_in [AXES];

   // Captured request.
   logic [TIME_W-1:0]       time_ff;
   logic signed [RAW_W-1:0] raw_ff [AXES];
   logic signed [RAW_W-1:0] raw_req [AXES];
   logic                    ts_ff;

   // Scaled key and frame.
   logic signed [POS_W-1:0] key_pos_ff [AXES];
   logic [FRAME_W-1:0]      frame_ff, frame_in;
   logic [PROD_W-1:0]       time_prod;
   logic [PROD_W-TIME_FRAC-1:0] frame_raw;

   // Previous key.
   logic signed [POS_W-1:0] prev_pos_ff [AXES];
   logic [FRAME_W-1:0]      prev_frame_ff;
   logic                    prev_valid_ff;

   // Gap decision.
   logic                    prev_live;
   logic                    forward;
   logic [FRAME_W-1:0]      gap_full;
   logic                    gap_over;
   logic [GAP_W-1:0]        gap_ff;
   logic                    ovf_ff;
   logic [GAP_W-1:0]        step_ff;
   logic [GAP_W-1:0]        gap_m1;

   // Fill arithmetic.
   logic signed [DIFF_W-1:0] diff_ff [AXES];
   logic [DIFF_W-1:0]        acc_q_ff [AXES];
   logic [GAP_W-1:0]         acc_r_ff [AXES];
   logic signed [POS_W-1:0]  fill_pos [AXES];
   logic [AXES-1:0]          div_done;

   // Output register.
   logic                    out_valid_ff, out_valid_in;
   logic signed [POS_W-1:0] out_pos_ff [AXES];
   logic                    out_fill_ff;
   logic                    out_ovf_ff;
   logic                    out_last_ff;
   logic                    slot_free;

   assign raw_req[0] = req_raw_x;
   assign raw_req[1] = req_raw_y;
   assign raw_req[2] = req_raw_z;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         scale_in[a] = scale_ff[a];
      end
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCALE_X: scale_in[0] = csr_wr_data;
            CSR_SCALE_Y: scale_in[1] = csr_wr_data;
            CSR_SCALE_Z: scale_in[2] = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            scale_ff[a] <= SCALE_RESET;
         end
      end else begin
         scale_ff <= scale_in;
      end
   end

   // Frame number: time times the frame rate, fraction dropped, saturated.
   assign time_prod = PROD_W'(time_ff) * PROD_W'(FRAME_RATE);
   assign frame_raw = time_prod[PROD_W-1:TIME_FRAC];
   assign frame_in  = (frame_raw > (PROD_W-TIME_FRAC)'(FRAME_MAX)) ?
                      FRAME_W'(FRAME_MAX) : FRAME_W'(frame_raw);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         time_ff <= req_key_time;
         raw_ff  <= raw_req;
         ts_ff   <= req_track_start;
      end
      if (cmd.calc) begin
         frame_ff <= frame_in;
      end
   end

   // Gap classification against the previous key.
   assign prev_live = prev_valid_ff & ~ts_ff;
   assign forward   = frame_ff > prev_frame_ff;
   assign gap_full  = frame_ff - prev_frame_ff;
   assign gap_over  = gap_full > FRAME_W'(MAX_GAP);
   assign gap_m1    = gap_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         gap_ff <= gap_full[GAP_W-1:0];
         ovf_ff <= prev_live & forward & gap_over;
      end
      if (cmd.fill_init) begin
         step_ff <= GAP_W'(1);
      end else if (cmd.emit_fill) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_frame_ff <= '0;
         prev_valid_ff <= 1'b0;
      end else if (cmd.emit_key || cmd.skip_key) begin
         prev_frame_ff <= frame_ff;
         prev_valid_ff <= 1'b1;
      end
   end

   for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
      logic signed [SCALE_W+RAW_W:0] key_prod;
      logic [DIFF_W-1:0]             diff_mag;
      logic                          diff_neg;
      logic [DIFF_W-1:0]             quot;
      logic [GAP_W-1:0]              rem;
      logic [GAP_W:0]                r_sum;
      logic                          r_carry;
      logic [GAP_W:0]                r_sub;
      logic signed [DIFF_W:0]        fill_sum;

      assign key_prod = $signed({1'b0, scale_ff[ax]}) * raw_ff[ax];
      assign diff_neg = diff_ff[ax][DIFF_W-1];
      assign diff_mag = diff_neg ? DIFF_W'(-diff_ff[ax]) : DIFF_W'(diff_ff[ax]);

      kfr_divider u_div (
         .clock     (clock),
         .reset     (reset),
         .start     (cmd.div_start),
         .dividend  (diff_mag),
         .divisor   (gap_ff),
         .quotient  (quot),
         .remainder (rem),
         .done      (div_done[ax])
      );

      // Running floor(|diff| * j / gap): add quotient and remainder per step.
      assign r_sum   = {1'b0, acc_r_ff[ax]} + {1'b0, rem};
      assign r_carry = r_sum >= {1'b0, gap_ff};
      assign r_sub   = r_sum - {1'b0, gap_ff};

      // Truncation toward zero: the magnitude quotient takes the diff's sign.
      assign fill_sum = $signed({{2{prev_pos_ff[ax][POS_W-1]}}, prev_pos_ff[ax]})
                      + $signed({1'b0, acc_q_ff[ax] ^ {DIFF_W{diff_neg}}})
                      + $signed({{DIFF_W{1'b0}}, diff_neg});
      assign fill_pos[ax] = fill_sum[POS_W-1:0];

      always_ff @(posedge clock) begin
         if (cmd.calc) begin
            key_pos_ff[ax] <= key_prod[POS_W-1:0];
         end
         if (cmd.decide) begin
            diff_ff[ax] <= DIFF_W'(key_pos_ff[ax]) - DIFF_W'(prev_pos_ff[ax]);
         end
         if (cmd.fill_init) begin
            acc_q_ff[ax] <= quot;
            acc_r_ff[ax] <= rem;
         end else if (cmd.emit_fill) begin
            acc_q_ff[ax] <= acc_q_ff[ax] + quot + DIFF_W'(r_carry);
            acc_r_ff[ax] <= r_carry ? r_sub[GAP_W-1:0] : r_sum[GAP_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            prev_pos_ff[ax] <= '0;
         end else if (cmd.emit_key) begin
            prev_pos_ff[ax] <= key_pos_ff[ax];
         end
      end
   end

   // Response register; a new response may load as the old one leaves.
   assign slot_free = ~out_valid_ff | rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_ready;
      if (cmd.emit_fill || cmd.emit_key) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_fill) begin
         out_pos_ff  <= fill_pos;
         out_fill_ff <= 1'b1;
         out_ovf_ff  <= 1'b0;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_key) begin
         out_pos_ff  <= key_pos_ff;
         out_fill_ff <= 1'b0;
         out_ovf_ff  <= ovf_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign status.emit_needed = ~prev_live | (frame_ff != prev_frame_ff);
   assign status.fill_needed = prev_live & forward & (gap_full >= FRAME_W'(2)) & ~gap_over;
   assign status.div_done    = &div_done;
   assign status.fill_last   = (step_ff == gap_m1);
   assign status.slot_free   = slot_free;

   assign rsp_valid        = out_valid_ff;
   assign rsp_pos_x        = out_pos_ff[0];
   assign rsp_pos_y        = out_pos_ff[1];
   assign rsp_pos_z        = out_pos_ff[2];
   assign rsp_is_fill      = out_fill_ff;
   assign rsp_gap_overflow = out_ovf_ff;
   assign rsp_last_of_run  = out_last_ff;

`ifndef SYNTHESIS
   a_load_needs_slot : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_fill || cmd.emit_key) |-> (!out_valid_ff || rsp_ready))
      else $error("response loaded over an untaken response");

   a_fill_flags : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_fill |=> (out_valid_ff && out_fill_ff && !out_last_ff && !out_ovf_ff))
      else $error("fill response carries wrong flags");

   a_fill_in_gap : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_fill |-> (step_ff != '0 && step_ff < gap_ff))
      else $error("fill step outside the frame gap");

   a_div_idle_at_start : assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (&div_done))
      else $error("divider restarted while busy");
`endif

endmodule

FILE: design/kfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe resampler controller
// Sequences one key through scaling, gap decision, division and the fill
// and key responses.
// ----------------------------------------------------------------------------
module kfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  kfr_pkg::kfr_status_type status,
   output kfr_pkg::kfr_cmd_type    cmd
);
   import kfr_pkg::*;

   kfr_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.emit_needed) begin
               state_in = ST_IDLE;
            end else if (status.fill_needed) begin
               state_in = ST_DIV_START;
            end else begin
               state_in = ST_KEY_OUT;
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (status.slot_free && status.fill_last) begin
               state_in = ST_KEY_OUT;
            end
         end
         ST_KEY_OUT: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide   = 1'b1;
            cmd.skip_key = ~status.emit_needed;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
         end
         ST_DIV_WAIT: begin
            cmd.fill_init = status.div_done;
         end
         ST_FILL: begin
            cmd.emit_fill = status.slot_free;
         end
         ST_KEY_OUT: begin
            cmd.emit_key = status.slot_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/keyframe_frame_rate_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe frame-rate resampler
// Turns one bone's translation keys into per-frame positions, filling
// skipped frames by linear interpolation unless the gap exceeds 64 frames.
//
//   channel  direction  contents
//   req_ch   in         key_time, raw_x/y/z, track_start
//   rsp_ch   out        pos_x/y/z, is_fill, gap_overflow, last_of_run
//   csr_*    in         scale_x, scale_y, scale_z write port
//
// A key with no fill passes through scaling, gap decision and the key response;
// a key on an unchanged frame is dropped at the gap decision with no response.
// A key that fills a gap also waits for the bit-serial gap divider to produce
// its 41 quotient bits and then emits one fill response per skipped frame.
// A stalled response holds the controller in its fill or key step.
// Reset is synchronous; scales return to 1.0 and the previous key is forgotten.
// ----------------------------------------------------------------------------
module keyframe_frame_rate_resampler (
   input  logic                           clock,
   input  logic                           reset,
   kfr_req_if.sink                        req_ch,
   kfr_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [kfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kfr_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import kfr_pkg::*;

   kfr_cmd_type    cmd;
   kfr_status_type status;

   kfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_key_time     (req_ch.key_time),
      .req_raw_x        (req_ch.raw_x),
      .req_raw_y        (req_ch.raw_y),
      .req_raw_z        (req_ch.raw_z),
      .req_track_start  (req_ch.track_start),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_pos_x        (rsp_ch.pos_x),
      .rsp_pos_y        (rsp_ch.pos_y),
      .rsp_pos_z        (rsp_ch.pos_z),
      .rsp_is_fill      (rsp_ch.is_fill),
      .rsp_gap_overflow (rsp_ch.gap_overflow),
      .rsp_last_of_run  (rsp_ch.last_of_run)
   );

endmodule
